// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define PSU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// plain condition that must hold at every rising edge outside reset
`define PSU_ASSERT_ALWAYS(label, cond, msg) \
   `PSU_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

// ===== rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// types, constants and codes of the priority semaphore unit
// ----------------------------------------------------------------------------
package psu_pkg;

   // wait queue size and derived widths
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // field widths
   localparam int VAL_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int WAITERS_W = 5;

   // command codes
   localparam logic CMD_WAIT = 1'b0;
   localparam logic CMD_POST = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANTED  = 3'd0,
      STAT_QUEUED   = 3'd1,
      STAT_HANDED   = 3'd2,
      STAT_RELEASED = 3'd3,
      STAT_OVERPOST = 3'd4,
      STAT_FULL     = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_LAST,
      ST_DEQ
   } state_type;

   // one queue entry
   typedef struct packed {
      logic [VAL_W-1:0] prio;
      logic [VAL_W-1:0] id;
   } entry_type;

   // shared compare unit result
   typedef struct packed {
      logic ge;
      logic eq;
   } cmp_res_type;

endpackage

// ===== rtl/priority_semaphore_unit.sv =====
// ----------------------------------------------------------------------------
// priority_semaphore_unit
// counting semaphore with a priority-ordered wait queue held in a ring ram
// ----------------------------------------------------------------------------
//  channel   ports                               direction  handshake
//  request   start busy req_cmd req_task_id      in         start & !busy
//            req_priority_req
//  response  rsp_valid rsp_status rsp_woken_*    out        rsp_valid strobe
//            rsp_tokens_held rsp_waiters_now
//  csr       csr_valid csr_ready csr_data        in         valid & ready
//
//  grant, release, over-post, queue-full and a wait into an empty queue end in
//  the idle state; a hand-off to a waiter reads the head in the dequeue state.
//  any other queued wait walks back from the tail one entry a cycle through
//  the ram and comparator, moving each waiter of lower priority one place on.
//  the response appears the cycle after the transaction completes; busy is
//  low again in that same cycle. reset is synchronous, no clearing pass.
//  the receiver cannot stall; csr writes are always taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_semaphore_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [psu_pkg::VAL_W-1:0]            req_task_id,
   input  logic [psu_pkg::VAL_W-1:0]            req_priority_req,
   output logic                                 rsp_valid,
   output logic [psu_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_woken_valid,
   output logic [psu_pkg::VAL_W-1:0]            rsp_woken_task,
   output logic [psu_pkg::VAL_W-1:0]            rsp_tokens_held,
   output logic [psu_pkg::WAITERS_W-1:0]        rsp_waiters_now,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [psu_pkg::VAL_W-1:0]            csr_data
);

   psu_pkg::state_type              state_ff, state_in;
   logic [psu_pkg::IDX_W-1:0]       head_ff, head_in;
   logic [psu_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [psu_pkg::VAL_W-1:0]       tokens_ff, tokens_in;
   logic [psu_pkg::VAL_W-1:0]       max_ff;
   logic [psu_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [psu_pkg::IDX_W-1:0]       k_ff, k_in;
   psu_pkg::entry_type              new_ff, new_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   psu_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                            rsp_woken_valid_ff, rsp_woken_valid_in;
   logic [psu_pkg::VAL_W-1:0]       rsp_woken_task_ff, rsp_woken_task_in;
   logic [psu_pkg::VAL_W-1:0]       rsp_tokens_ff, rsp_tokens_in;
   logic [psu_pkg::WAITERS_W-1:0]   rsp_waiters_ff, rsp_waiters_in;

   logic                            ram_wr_en;
   logic [psu_pkg::IDX_W-1:0]       ram_wr_addr;
   psu_pkg::entry_type              ram_wr_data;
   logic [psu_pkg::IDX_W-1:0]       ram_rd_addr;
   logic [$bits(psu_pkg::entry_type)-1:0] ram_rd_bits;
   psu_pkg::entry_type              ram_rd_data;

   logic [psu_pkg::VAL_W-1:0]       cmp_a, cmp_b;
   psu_pkg::cmp_res_type            cmp_res;

   logic                            accept;

   // ring index helpers
   function automatic logic [psu_pkg::IDX_W-1:0] ring_add(
      input logic [psu_pkg::IDX_W-1:0] a,
      input logic [psu_pkg::IDX_W-1:0] b
   );
      logic [psu_pkg::IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= psu_pkg::DEPTH_X) begin
         s = s - psu_pkg::DEPTH_X;
      end
      return s[psu_pkg::IDX_W-1:0];
   endfunction

   function automatic logic [psu_pkg::IDX_W-1:0] ring_next(
      input logic [psu_pkg::IDX_W-1:0] p
   );
      return (p == psu_pkg::LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [psu_pkg::IDX_W-1:0] ring_prev(
      input logic [psu_pkg::IDX_W-1:0] p
   );
      return (p == '0) ? psu_pkg::LAST_IDX : p - 1'b1;
   endfunction

   // wait queue storage
   psu_ram #(
      .WIDTH ($bits(psu_pkg::entry_type)),
      .DEPTH (psu_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = psu_pkg::entry_type'(ram_rd_bits);

   // shared compare unit
   psu_cmp u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

   assign accept    = start && (state_ff == psu_pkg::ST_IDLE);
   assign busy      = (state_ff != psu_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // compare operand selection
   always_comb begin
      cmp_a = tokens_ff;
      cmp_b = max_ff;
      if (state_ff == psu_pkg::ST_INSERT) begin
         cmp_a = ram_rd_data.prio;
         cmp_b = new_ff.prio;
      end else if (req_cmd == psu_pkg::CMD_POST) begin
         cmp_b = '0;
      end
   end

   // sequencer next state and datapath control
   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      count_in           = count_ff;
      tokens_in          = tokens_ff;
      pos_in             = pos_ff;
      k_in               = k_ff;
      new_in             = new_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_woken_valid_in = 1'b0;
      rsp_woken_task_in  = '0;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = ring_next(pos_ff);
      ram_wr_data        = new_ff;
      ram_rd_addr        = head_ff;

      case (state_ff)
         psu_pkg::ST_IDLE: begin
            if (accept) begin
               new_in = '{prio: req_priority_req, id: req_task_id};
               if (req_cmd == psu_pkg::CMD_WAIT) begin
                  if (!cmp_res.ge) begin
                     tokens_in     = tokens_ff + 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psu_pkg::STAT_GRANTED;
                  end else if (count_ff == psu_pkg::DEPTH_CNT) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psu_pkg::STAT_FULL;
                  end else if (count_ff == '0) begin
                     // empty queue: the new task is the head
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = head_ff;
                     ram_wr_data   = '{prio: req_priority_req, id: req_task_id};
                     count_in      = count_ff + 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psu_pkg::STAT_QUEUED;
                  end else begin
                     // start walking back from the tail
                     k_in        = psu_pkg::IDX_W'(count_ff - 1'b1);
                     pos_in      = ring_add(head_ff, psu_pkg::IDX_W'(count_ff - 1'b1));
                     ram_rd_addr = pos_in;
                     state_in    = psu_pkg::ST_INSERT;
                  end
               end else begin
                  if (count_ff != '0) begin
                     ram_rd_addr = head_ff;
                     state_in    = psu_pkg::ST_DEQ;
                  end else if (cmp_res.eq) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psu_pkg::STAT_OVERPOST;
                  end else begin
                     tokens_in     = tokens_ff - 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psu_pkg::STAT_RELEASED;
                  end
               end
            end
         end

         psu_pkg::ST_INSERT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ring_next(pos_ff);
            if (cmp_res.ge) begin
               // entry outranks or ties: new task goes just behind it
               ram_wr_data   = new_ff;
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = psu_pkg::STAT_QUEUED;
               state_in      = psu_pkg::ST_IDLE;
            end else begin
               // shift the entry one place towards the tail
               ram_wr_data = ram_rd_data;
               if (k_ff == '0) begin
                  state_in = psu_pkg::ST_LAST;
               end else begin
                  pos_in      = ring_prev(pos_ff);
                  k_in        = k_ff - 1'b1;
                  ram_rd_addr = ring_prev(pos_ff);
               end
            end
         end

         psu_pkg::ST_LAST: begin
            // new task becomes the head
            ram_wr_en     = 1'b1;
            ram_wr_addr   = pos_ff;
            ram_wr_data   = new_ff;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = psu_pkg::STAT_QUEUED;
            state_in      = psu_pkg::ST_IDLE;
         end

         psu_pkg::ST_DEQ: begin
            head_in            = ring_next(head_ff);
            count_in           = count_ff - 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_status_in      = psu_pkg::STAT_HANDED;
            rsp_woken_valid_in = 1'b1;
            rsp_woken_task_in  = ram_rd_data.id;
            state_in           = psu_pkg::ST_IDLE;
         end

         default: begin
            state_in = psu_pkg::ST_IDLE;
         end
      endcase

      rsp_tokens_in  = tokens_in;
      rsp_waiters_in = psu_pkg::WAITERS_W'(count_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psu_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         tokens_ff    <= '0;
         max_ff       <= psu_pkg::VAL_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         tokens_ff    <= tokens_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      k_ff               <= k_in;
      new_ff             <= new_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_woken_valid_ff <= rsp_woken_valid_in;
      rsp_woken_task_ff  <= rsp_woken_task_in;
      rsp_tokens_ff      <= rsp_tokens_in;
      rsp_waiters_ff     <= rsp_waiters_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_woken_valid = rsp_woken_valid_ff;
   assign rsp_woken_task  = rsp_woken_task_ff;
   assign rsp_tokens_held = rsp_tokens_ff;
   assign rsp_waiters_now = rsp_waiters_ff;

   // checks
   `PSU_ASSERT_ALWAYS(a_count_bound, count_ff <= psu_pkg::DEPTH_CNT,
      "wait queue count beyond depth")
   `PSU_ASSERT(a_insert_nonempty, state_ff == psu_pkg::ST_INSERT |-> count_ff != '0,
      "insert walk on an empty queue")
   `PSU_ASSERT(a_head_moves_on_deq, state_ff != psu_pkg::ST_DEQ |=> $stable(head_ff),
      "queue head moved outside a hand-off")
   `PSU_ASSERT(a_grant_next, accept && req_cmd == psu_pkg::CMD_WAIT && tokens_ff < max_ff
      |=> rsp_valid && rsp_status == psu_pkg::STAT_GRANTED,
      "free token not granted in the next cycle")

endmodule

// ===== rtl/psu_ram.sv =====
// ----------------------------------------------------------------------------
// psu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module psu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psu_cmp.sv =====
// ----------------------------------------------------------------------------
// psu_cmp
// shared unsigned compare unit of the semaphore sequencer
// ----------------------------------------------------------------------------
module psu_cmp (
   input  logic [psu_pkg::VAL_W-1:0] op_a,
   input  logic [psu_pkg::VAL_W-1:0] op_b,
   output psu_pkg::cmp_res_type      res
);

   // one subtract gives both the order and equality
   logic [psu_pkg::VAL_W:0] diff;

   always_comb begin
      diff   = {1'b0, op_a} - {1'b0, op_b};
      res.ge = ~diff[psu_pkg::VAL_W];
      res.eq = (diff == '0);
   end

endmodule

// ===== sim/tb_priority_semaphore_unit.sv =====
// ----------------------------------------------------------------------------
// tb_priority_semaphore_unit
// self-checking bench for the priority semaphore unit: a directed table of
// semaphore operations and then random phases under several token limits;
// every response is checked field by field against a hand-written row or an
// in-bench model of the token count and the priority-ordered wait queue
// ----------------------------------------------------------------------------
module tb_priority_semaphore_unit;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      psu_pkg::status_type             status;
      logic                            woken_valid;
      logic [psu_pkg::VAL_W-1:0]       woken_task;
      logic [psu_pkg::VAL_W-1:0]       tokens_held;
      logic [psu_pkg::WAITERS_W-1:0]   waiters_now;
   } outcome_type;

   // one row of the directed table
   typedef struct packed {
      logic                            cmd;
      logic [psu_pkg::VAL_W-1:0]       task_id;
      logic [psu_pkg::VAL_W-1:0]       prio;
      logic                            typed;
      outcome_type                     outcome;
   } directed_row_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_cmd;
   logic [psu_pkg::VAL_W-1:0]       req_task_id;
   logic [psu_pkg::VAL_W-1:0]       req_priority_req;
   logic                            rsp_valid;
   logic [psu_pkg::STATUS_W-1:0]    rsp_status;
   logic                            rsp_woken_valid;
   logic [psu_pkg::VAL_W-1:0]       rsp_woken_task;
   logic [psu_pkg::VAL_W-1:0]       rsp_tokens_held;
   logic [psu_pkg::WAITERS_W-1:0]   rsp_waiters_now;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [psu_pkg::VAL_W-1:0]       csr_data;

   // a hand-written expectation travels with its transaction
   logic                            row_typed;
   outcome_type                     row_outcome;

   // semaphore model state
   logic [psu_pkg::VAL_W-1:0]       sem_limit;
   logic [psu_pkg::VAL_W-1:0]       sem_tokens;
   int                              sem_waiters;
   logic [psu_pkg::VAL_W-1:0]       wait_ids[psu_pkg::QUEUE_DEPTH];
   logic [psu_pkg::VAL_W-1:0]       wait_prios[psu_pkg::QUEUE_DEPTH];

   outcome_type            expected_outcomes[$];
   directed_row_type       directed_rows[$];
   outcome_type            blank_outcome;
   int                     mismatch_count;
   int                     sent_count;
   int                     checked_count;

   priority_semaphore_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_task   (rsp_woken_task),
      .rsp_tokens_held  (rsp_tokens_held),
      .rsp_waiters_now  (rsp_waiters_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(12 * 400000);
      $display("[priority_semaphore_unit] ERROR");
      $finish;
   end

   // wait or post applied to the model, returns the response it should give
   function automatic outcome_type semaphore_outcome(
      input logic cmd,
      input logic [psu_pkg::VAL_W-1:0] id,
      input logic [psu_pkg::VAL_W-1:0] prio);
      outcome_type o;
      int          pos;
      int          i;
      o.woken_valid = 1'b0;
      o.woken_task  = '0;
      if (cmd == psu_pkg::CMD_WAIT) begin
         if (sem_tokens < sem_limit) begin
            sem_tokens = sem_tokens + 1'b1;
            o.status   = psu_pkg::STAT_GRANTED;
         end else if (sem_waiters >= psu_pkg::QUEUE_DEPTH) begin
            o.status = psu_pkg::STAT_FULL;
         end else begin
            // behind every waiter of equal or higher priority
            pos = 0;
            while (pos < sem_waiters && wait_prios[pos] >= prio)
               pos++;
            for (i = sem_waiters; i > pos; i--) begin
               wait_ids[i]   = wait_ids[i-1];
               wait_prios[i] = wait_prios[i-1];
            end
            wait_ids[pos]   = id;
            wait_prios[pos] = prio;
            sem_waiters++;
            o.status = psu_pkg::STAT_QUEUED;
         end
      end else begin
         if (sem_waiters > 0) begin
            // hand the token to the head, count unchanged
            o.woken_valid = 1'b1;
            o.woken_task  = wait_ids[0];
            for (i = 1; i < sem_waiters; i++) begin
               wait_ids[i-1]   = wait_ids[i];
               wait_prios[i-1] = wait_prios[i];
            end
            sem_waiters--;
            o.status = psu_pkg::STAT_HANDED;
         end else if (sem_tokens == 0) begin
            o.status = psu_pkg::STAT_OVERPOST;
         end else begin
            sem_tokens = sem_tokens - 1'b1;
            o.status   = psu_pkg::STAT_RELEASED;
         end
      end
      o.tokens_held = sem_tokens;
      o.waiters_now = psu_pkg::WAITERS_W'(sem_waiters);
      return o;
   endfunction

   // response checking, register tracking and prediction at each edge
   always @(posedge clock) begin : monitor
      outcome_type want;
      outcome_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            checked_count++;
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response with no transaction pending: status %0d", rsp_status);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status != want.status || rsp_woken_valid != want.woken_valid ||
                   rsp_woken_task != want.woken_task ||
                   rsp_tokens_held != want.tokens_held ||
                   rsp_waiters_now != want.waiters_now) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch (expected/actual): status %0d/%0d woken %0d/%0d",
                              want.status, rsp_status, want.woken_valid, rsp_woken_valid);
                     $display("   task %0d/%0d tokens %0d/%0d waiters %0d/%0d",
                              want.woken_task, rsp_woken_task, want.tokens_held,
                              rsp_tokens_held, want.waiters_now, rsp_waiters_now);
                  end
               end
            end
         end
         if (csr_valid && csr_ready)
            sem_limit = csr_data;
         if (start && !busy) begin
            predicted = semaphore_outcome(req_cmd, req_task_id, req_priority_req);
            expected_outcomes.push_back(row_typed ? row_outcome : predicted);
         end
      end
   end

   // one transaction, after an optional idle gap of the sender
   task automatic send_op(input logic cmd, input logic [psu_pkg::VAL_W-1:0] id,
                          input logic [psu_pkg::VAL_W-1:0] prio, input logic typed,
                          input outcome_type outcome, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_task_id      <= id;
      req_priority_req <= prio;
      row_typed        <= typed;
      row_outcome      <= outcome;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   // sender holds off until every response is back
   task automatic drain;
      start     <= 1'b0;
      row_typed <= 1'b0;
      while (checked_count != sent_count) @(posedge clock);
   endtask

   task automatic write_limit(input logic [psu_pkg::VAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(input logic cmd, input logic [psu_pkg::VAL_W-1:0] id,
                                   input logic [psu_pkg::VAL_W-1:0] prio,
                                   input logic typed, input psu_pkg::status_type st,
                                   input logic [psu_pkg::VAL_W-1:0] tokens,
                                   input logic [psu_pkg::WAITERS_W-1:0] waiters);
      directed_row_type r;
      r.cmd                 = cmd;
      r.task_id             = id;
      r.prio                = prio;
      r.typed               = typed;
      r.outcome.status      = st;
      r.outcome.woken_valid = 1'b0;
      r.outcome.woken_task  = '0;
      r.outcome.tokens_held = tokens;
      r.outcome.waiters_now = waiters;
      directed_rows.push_back(r);
   endfunction

   // stimulus
   initial begin : stimulus
      int phase_limit[7];
      int phase_items[7];
      int phase_wait_pct[7];
      int phase_idle_pct[7];
      int p;
      int n;
      int k;
      int gap;
      logic cmd;
      logic [psu_pkg::VAL_W-1:0] prio;

      phase_limit      = '{1, 255, 0, 3, 8, 2, 0};
      phase_items      = '{180, 260, 150, 200, 140, 160, 240};
      phase_wait_pct   = '{55, 88, 60, 50, 75, 40, 50};
      phase_idle_pct   = '{0, 73, 16, 73, 0, 16, 73};

      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = psu_pkg::CMD_WAIT;
      req_task_id      = '0;
      req_priority_req = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      row_typed        = 1'b0;
      row_outcome      = '0;
      blank_outcome    = '0;
      sem_limit        = 8'd1;
      sem_tokens       = '0;
      sem_waiters      = 0;
      mismatch_count   = 0;
      sent_count       = 0;
      checked_count    = 0;

      // over-post, grant, sixteen waiters with ties and extremes, queue full, hand-offs
      add_row(psu_pkg::CMD_POST, 8'hFF, 8'hFF, 1'b1, psu_pkg::STAT_OVERPOST, 8'd0, 5'd0);
      add_row(psu_pkg::CMD_WAIT, 8'h00, 8'h00, 1'b1, psu_pkg::STAT_GRANTED,  8'd1, 5'd0);
      add_row(psu_pkg::CMD_WAIT, 8'hFF, 8'h00, 1'b1, psu_pkg::STAT_QUEUED,   8'd1, 5'd1);
      add_row(psu_pkg::CMD_WAIT, 8'h11, 8'hFF, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd2);
      add_row(psu_pkg::CMD_WAIT, 8'h22, 8'h80, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd3);
      add_row(psu_pkg::CMD_WAIT, 8'h33, 8'h80, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd4);
      add_row(psu_pkg::CMD_WAIT, 8'h44, 8'h01, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd5);
      add_row(psu_pkg::CMD_WAIT, 8'h55, 8'hFE, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd6);
      add_row(psu_pkg::CMD_WAIT, 8'h66, 8'h80, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd7);
      add_row(psu_pkg::CMD_WAIT, 8'h77, 8'h00, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd8);
      add_row(psu_pkg::CMD_WAIT, 8'h88, 8'h7F, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd9);
      add_row(psu_pkg::CMD_WAIT, 8'h99, 8'hFF, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd10);
      add_row(psu_pkg::CMD_WAIT, 8'hAA, 8'h40, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd11);
      add_row(psu_pkg::CMD_WAIT, 8'hBB, 8'h40, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd12);
      add_row(psu_pkg::CMD_WAIT, 8'hCC, 8'hC0, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd13);
      add_row(psu_pkg::CMD_WAIT, 8'hDD, 8'h01, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd14);
      add_row(psu_pkg::CMD_WAIT, 8'hEE, 8'h20, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd15);
      add_row(psu_pkg::CMD_WAIT, 8'h01, 8'h80, 1'b0, psu_pkg::STAT_QUEUED,   8'd1, 5'd16);
      add_row(psu_pkg::CMD_WAIT, 8'h5A, 8'hFF, 1'b1, psu_pkg::STAT_FULL,     8'd1, 5'd16);
      add_row(psu_pkg::CMD_POST, 8'hFF, 8'hFF, 1'b0, psu_pkg::STAT_HANDED,   8'd1, 5'd15);
      add_row(psu_pkg::CMD_POST, 8'h00, 8'h00, 1'b0, psu_pkg::STAT_HANDED,   8'd1, 5'd14);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < directed_rows.size(); k++)
         send_op(directed_rows[k].cmd, directed_rows[k].task_id, directed_rows[k].prio,
                 directed_rows[k].typed, directed_rows[k].outcome, (k % 3 == 2) ? 1 : 0);
      drain();

      // random phases, each under its own token limit; the limit 8 phase is
      // followed by limit 2 so that the held count sits above the limit
      for (p = 0; p < 7; p++) begin
         write_limit((p == 6) ? psu_pkg::VAL_W'($urandom_range(1, 254))
                              : psu_pkg::VAL_W'(phase_limit[p]));
         for (n = 0; n < phase_items[p]; n++) begin
            cmd  = ($urandom_range(0, 99) < phase_wait_pct[p]) ? psu_pkg::CMD_WAIT
                                                                : psu_pkg::CMD_POST;
            // narrow priorities now and then so that ties are common
            prio = $urandom_range(0, 1) ? psu_pkg::VAL_W'($urandom_range(0, 3))
                                        : psu_pkg::VAL_W'($urandom_range(0, 255));
            gap  = ($urandom_range(0, 99) < phase_idle_pct[p]) ? $urandom_range(1, 6) : 0;
            send_op(cmd, psu_pkg::VAL_W'($urandom_range(0, 255)), prio, 1'b0,
                    blank_outcome, gap);
            if ($urandom_range(0, 63) == 0)
               drain();
         end
         drain();
      end

      // settle, then report
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("[priority_semaphore_unit] OK");
      else
         $display("[priority_semaphore_unit] ERROR");
      $finish;
   end

endmodule
